[hw/rtl/gbn_pkg.sv]
`timescale 1ns / 1ps
package gbn_pkg;
  localparam int unsigned SeqW = 32;
  localparam int unsigned CfgW = 5;
  localparam int unsigned OpW = 2;
  localparam int unsigned CmdW = 2;
  localparam logic [CfgW-1:0] ResetWindow = 5'd10;

  typedef enum logic [OpW-1:0] {
    OP_MSG = 2'd0,
    OP_ACK = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CmdW-1:0] {
    TMR_NONE = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP = 2'd2
  } timer_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_SEND,
    ST_READ,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
  } payload_t;

  typedef struct packed {
    op_t          op;
    logic [31:0]  pkt_seq;
    logic [31:0]  pkt_ack;
    logic signed [31:0] pkt_checksum;
    payload_t     payload;
  } in_item_t;

  typedef struct packed {
    logic         pkt_valid;
    logic [31:0]  out_seq;
    logic [31:0]  out_ack;
    logic signed [31:0] out_checksum;
    payload_t     payload;
    timer_cmd_t   timer_cmd;
    logic         overflow;
    logic         last;
  } out_item_t;

  // One payload byte taken as a signed value, sign-extended to 32 bits.
  function automatic logic [31:0] sbyte(input logic [7:0] b);
    sbyte = {{24{b[7]}}, b};
  endfunction
endpackage

[hw/rtl/gbn_if.sv]
`timescale 1ns / 1ps
interface gbn_in_if
  import gbn_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gbn_out_if
  import gbn_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/go_back_n_sender.sv]
`timescale 1ns / 1ps
// Go-Back-N sender; one event is taken at a time and the input waits meanwhile.
// A message or timeout gives up to MAX_WINDOW packets one after another, each through
// store read, byte sum and output; a packet is not put out until the last one is taken.
// An ACK gives a result only if its checksum and ack check; a drop-only message gives an overflow flag.
// Synchronous active-high reset: window 1..1, empty store, timer off, window setting 10.
module go_back_n_sender
  import gbn_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 1024,
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CfgW-1:0] cfg_wdata,
  gbn_in_if.sink          in_ch,
  gbn_out_if.source       out_ch
);
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  logic [CfgW-1:0] window_cfg;
  logic [31:0]     window_base, next_seq;
  logic [AW-1:0]   oldest_index;
  logic [CW-1:0]   stored_count;
  logic            timer_running;
  state_t          state, state_next;
  in_item_t        item;
  logic            ovf;
  logic [31:0]     offset;
  logic [31:0]     limit;
  logic            sent_any;
  out_item_t       res;
  logic            res_valid;

  logic            sum_start, sum_done;
  logic [31:0]     sum_init, sum_total;
  payload_t        sum_bytes, rd_data;
  logic            st_we;

  // Store index a + b folded back into the buffer; a stays below the depth and b at most at it.
  function automatic logic [AW-1:0] wrap_idx(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    if (s >= 32'(BUFFER_DEPTH)) s = s - 32'(BUFFER_DEPTH);
    return AW'(s);
  endfunction

  // Result without a packet.
  function automatic out_item_t plain_item(input timer_cmd_t cmd, input logic ovf_bit);
    out_item_t r;
    r = '0;
    r.timer_cmd = cmd;
    r.overflow = ovf_bit;
    r.last = 1'b1;
    return r;
  endfunction

  // Effective window, clamped to 1..MAX_WINDOW.
  logic [31:0] eff_w;
  always_comb begin
    eff_w = 32'(window_cfg);
    if (eff_w < 32'd1) eff_w = 32'd1;
    if (eff_w > 32'(MAX_WINDOW)) eff_w = 32'(MAX_WINDOW);
  end

  logic [31:0] outstanding, ack_off;
  assign outstanding = next_seq - window_base;
  assign ack_off = item.pkt_ack - window_base;
  logic [31:0] seq_cur;
  assign seq_cur = window_base + offset;

  // A timeout resends the outstanding packets, bounded by the store and the window.
  logic [31:0] tmo_limit;
  always_comb begin
    tmo_limit = outstanding;
    if (tmo_limit > 32'(stored_count)) tmo_limit = 32'(stored_count);
    if (tmo_limit > eff_w) tmo_limit = eff_w;
  end

  gbn_store #(.Depth(BUFFER_DEPTH)) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(wrap_idx(32'(oldest_index), 32'(stored_count))),
    .wdata(in_ch.data.payload),
    .raddr(wrap_idx(32'(oldest_index), offset)),
    .rdata(rd_data)
  );

  gbn_sum u_sum (
    .clk     (clk),
    .rst     (rst),
    .start   (sum_start),
    .init    (sum_init),
    .bytes_in(sum_bytes),
    .done    (sum_done),
    .total   (sum_total)
  );

  wire accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;
  assign st_we = accept && (in_ch.data.op == OP_MSG) &&
                 (32'(stored_count) < 32'(BUFFER_DEPTH));

  // Inputs to the shared summer depend on the kind of event.
  always_comb begin
    sum_start = 1'b0;
    sum_init = seq_cur + seq_cur;
    sum_bytes = rd_data;
    if (accept && in_ch.data.op == OP_ACK) begin
      sum_start = 1'b1;
      sum_init = in_ch.data.pkt_seq + in_ch.data.pkt_ack;
      sum_bytes = in_ch.data.payload;
    end else if (state == ST_READ) begin
      sum_start = 1'b1;
    end
  end

  // Packet result for the current offset.
  out_item_t pkt_res;
  logic      pkt_more;
  always_comb begin
    pkt_res = '0;
    pkt_res.pkt_valid = 1'b1;
    pkt_res.out_seq = seq_cur;
    pkt_res.out_ack = seq_cur;
    pkt_res.out_checksum = sum_total;
    pkt_res.payload = rd_data;
    pkt_res.overflow = ovf;
    pkt_res.timer_cmd = (offset == 32'd0) ? TMR_START : TMR_NONE;
    if (item.op == OP_MSG) begin
      pkt_more = (offset + 32'd1 < limit) && (offset + 32'd1 < 32'(stored_count));
    end else begin
      pkt_more = (offset + 32'd1 < limit);
    end
    pkt_res.last = !pkt_more;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.data.op)
            OP_MSG:     state_next = ST_SEND;
            OP_ACK:     state_next = ST_ACK;
            OP_TIMEOUT: state_next = ST_SEND;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ACK:  if (sum_done) state_next = ST_IDLE;
      ST_SEND: state_next = (offset < limit && offset < 32'(stored_count)) ? ST_READ : ST_IDLE;
      ST_READ: state_next = ST_SUM;
      ST_SUM:  if (sum_done) state_next = ST_OUT;
      ST_OUT:  if (!res_valid) state_next = ST_SEND;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_cfg <= ResetWindow;
      window_base <= 32'd1;
      next_seq <= 32'd1;
      oldest_index <= '0;
      stored_count <= '0;
      timer_running <= 1'b0;
      res_valid <= 1'b0;
      sent_any <= 1'b0;
    end else begin
      if (cfg_we) window_cfg <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item <= in_ch.data;
            sent_any <= 1'b0;
            ovf <= (in_ch.data.op == OP_MSG) && !st_we;
            offset <= (in_ch.data.op == OP_MSG) ? outstanding : 32'd0;
            limit <= (in_ch.data.op == OP_MSG) ? eff_w : tmo_limit;
            if (st_we) begin
              stored_count <= stored_count + CW'(1);
            end
          end
        end
        ST_ACK: begin
          if (sum_done && sum_total == item.pkt_checksum &&
              ack_off < outstanding && ack_off < 32'(stored_count)) begin
            oldest_index <= wrap_idx(32'(oldest_index), ack_off + 32'd1);
            stored_count <= stored_count - CW'(ack_off + 32'd1);
            window_base <= item.pkt_ack + 32'd1;
            timer_running <= (item.pkt_ack + 32'd1 != next_seq);
            res <= plain_item((item.pkt_ack + 32'd1 == next_seq) ? TMR_STOP : TMR_START,
                              1'b0);
            res_valid <= 1'b1;
          end
        end
        ST_SEND: begin
          if (!(offset < limit && offset < 32'(stored_count))) begin
            if (item.op == OP_MSG && ovf && !sent_any) begin
              res <= plain_item(TMR_NONE, 1'b1);
              res_valid <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (!res_valid) begin
            res <= pkt_res;
            timer_running <= 1'b1;
            if (item.op == OP_MSG) begin
              next_seq <= next_seq + 32'd1;
            end
            res_valid <= 1'b1;
            sent_any <= 1'b1;
            offset <= offset + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(stored_count) <= 32'(BUFFER_DEPTH)) else $error("store overfilled");
  a_out_window: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 32'(stored_count)) else $error("outstanding exceeds stored");
  a_timer_state: assert property (@(posedge clk) disable iff (rst)
    timer_running == (outstanding != 32'd0)) else $error("timer state out of step");
`endif
endmodule

[hw/rtl/gbn_sum.sv]
`timescale 1ns / 1ps
// Shared byte summing unit: adds one signed byte per cycle onto a running total.
module gbn_sum
  import gbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] init,
  input  payload_t    bytes_in,
  output logic        done,
  output logic [31:0] total
);
  logic [159:0] sh;
  logic [4:0]   cnt;
  logic         busy;

  // Shift the payload down one byte each step and accumulate.
  // Done rises for one cycle once the last byte is in the total.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      sh <= {bytes_in.hi, bytes_in.mid, bytes_in.lo};
      total <= init;
      cnt <= 5'd0;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd19);
      if (busy) begin
        total <= total + sbyte(sh[7:0]);
        sh <= {8'd0, sh[159:8]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd19) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

[hw/rtl/gbn_store.sv]
`timescale 1ns / 1ps
// Payload store, one write and one registered read port.
module gbn_store
  import gbn_pkg::*;
#(
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  payload_t                 wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output payload_t                 rdata
);
  payload_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
